/* hw/rtl/tes_pkg.sv */
// tes_pkg: shared types, codes, constants and lookup functions of the tone effect sequencer.
// Holds the note ROM, table lengths, LFSR step and constant-divisor remainder helper.
// No dependencies.
`timescale 1ns / 1ps

package tes_pkg;

	// Opcodes of an input transaction
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_PLAY  = 2'd1;
	localparam logic [1:0] OP_CHIRP = 2'd2;

	// Result actions
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_TONE    = 2'd1;
	localparam logic [1:0] ACT_SILENCE = 2'd2;

	// Effect ids for OP_PLAY
	localparam logic [3:0] FX_FIRST = 4'd1;
	localparam logic [3:0] FX_LAST  = 4'd8;
	localparam logic [3:0] FX_BURST = 4'd9;
	localparam logic [7:0] BURST_CHIRPS = 8'd15;

	// Random generator
	localparam logic [15:0] SEED_RESET = 16'd44257;
	localparam logic [15:0] LFSR_TAPS  = 16'hB400;

	// Chirp ranges (low inclusive, high exclusive)
	localparam int FREQ_LOW  = 600;
	localparam int FREQ_HIGH = 1600;
	localparam int DUR_LOW   = 20;
	localparam int DUR_HIGH  = 80;
	localparam int GAP_LOW   = 10;
	localparam int GAP_HIGH  = 80;

	localparam int FREQ_SPAN = FREQ_HIGH - FREQ_LOW;
	localparam int DUR_SPAN  = DUR_HIGH - DUR_LOW;
	localparam int GAP_SPAN  = GAP_HIGH - GAP_LOW;

	// Reciprocals rounded down, so the quotient estimate is low by at most one
	localparam int FREQ_K = 65536 / FREQ_SPAN;
	localparam int DUR_K  = 65536 / DUR_SPAN;
	localparam int GAP_K  = 65536 / GAP_SPAN;

	// Upper bound on a table's length; the longest table holds 12 notes
	localparam int MAX_NOTES = 16;

	typedef struct packed {
		logic [11:0] freq;
		logic [9:0]  dur;
		logic [8:0]  gap;
	} note_t;

	typedef struct packed {
		logic [11:0] freq;
		logic [9:0]  dur;
		logic [8:0]  gap;
		logic [15:0] lfsr;
	} chirp_draw_t;

	function automatic note_t mk_note(input int f, input int d, input int g);
		note_t n;
		n.freq = 12'(f);
		n.dur  = 10'(d);
		n.gap  = 9'(g);
		return n;
	endfunction

	// One Galois shift
	function automatic logic [15:0] lfsr_step(input logic [15:0] l);
		logic [15:0] n;
		n = l >> 1;
		if (l[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

	// x mod d for a constant 33 <= d <= 1023, k = floor(2^16 / d)
	function automatic logic [9:0] rem_const(input logic [15:0] x, input logic [9:0] d,
			input logic [10:0] k);
		logic [26:0] prod;
		logic [10:0] q;
		logic [21:0] qd;
		logic [16:0] r;
		prod = 27'(x) * 27'(k);
		q    = prod[26:16];
		qd   = 22'(q) * 22'(d);
		r    = 17'(x) - qd[16:0];
		if (r >= 17'(d)) begin
			r = r - 17'(d);
		end
		return r[9:0];
	endfunction

	function automatic logic [6:0] table_len(input logic [2:0] t);
		logic [6:0] n;
		case (t)
			3'd0: n = 7'd6;
			3'd1: n = 7'd5;
			3'd2: n = 7'd2;
			3'd3: n = 7'd2;
			3'd4: n = 7'd12;
			3'd5: n = 7'd1;
			3'd6: n = 7'd1;
			3'd7: n = 7'd3;
			default: n = 7'd0;
		endcase
		if (n > 7'(MAX_NOTES)) begin
			n = 7'(MAX_NOTES);
		end
		return n;
	endfunction

	function automatic note_t note_rom(input logic [2:0] t, input logic [3:0] i);
		note_t n;
		n = '0;
		case (t)
			3'd0: begin
				case (i)
					4'd0: n = mk_note(262, 80, 100);
					4'd1: n = mk_note(330, 80, 100);
					4'd2: n = mk_note(392, 80, 120);
					4'd3: n = mk_note(523, 120, 140);
					4'd4: n = mk_note(392, 100, 120);
					4'd5: n = mk_note(523, 250, 250);
					default: n = '0;
				endcase
			end
			3'd1: begin
				case (i)
					4'd0: n = mk_note(523, 100, 120);
					4'd1: n = mk_note(392, 100, 120);
					4'd2: n = mk_note(330, 120, 140);
					4'd3: n = mk_note(262, 150, 180);
					4'd4: n = mk_note(196, 250, 300);
					default: n = '0;
				endcase
			end
			3'd2: begin
				case (i)
					4'd0: n = mk_note(370, 150, 50);
					4'd1: n = mk_note(554, 150, 0);
					default: n = '0;
				endcase
			end
			3'd3: begin
				case (i)
					4'd0: n = mk_note(1200, 90, 100);
					4'd1: n = mk_note(1600, 150, 100);
					default: n = '0;
				endcase
			end
			3'd4: begin
				case (i)
					4'd0: n = mk_note(262, 80, 100);
					4'd1: n = mk_note(330, 80, 100);
					4'd2: n = mk_note(392, 80, 200);
					4'd3: n = mk_note(262, 80, 100);
					4'd4: n = mk_note(330, 80, 100);
					4'd5: n = mk_note(392, 80, 200);
					4'd6: n = mk_note(262, 80, 100);
					4'd7: n = mk_note(330, 80, 100);
					4'd8: n = mk_note(392, 80, 200);
					4'd9: n = mk_note(523, 120, 140);
					4'd10: n = mk_note(392, 100, 120);
					4'd11: n = mk_note(523, 250, 250);
					default: n = '0;
				endcase
			end
			3'd5: begin
				case (i)
					4'd0: n = mk_note(2100, 150, 170);
					default: n = '0;
				endcase
			end
			3'd6: begin
				case (i)
					4'd0: n = mk_note(262, 80, 100);
					default: n = '0;
				endcase
			end
			3'd7: begin
				case (i)
					4'd0: n = mk_note(600, 150, 180);
					4'd1: n = mk_note(500, 150, 180);
					4'd2: n = mk_note(400, 300, 0);
					default: n = '0;
				endcase
			end
			default: n = '0;
		endcase
		return n;
	endfunction

endpackage

/* hw/rtl/tes_draw.sv */
// tes_draw: random chirp parameters from three LFSR shifts.
// Depends on tes_pkg (LFSR step, remainder helper, chirp ranges).
`timescale 1ns / 1ps

module tes_draw (
	input  logic [15:0]          lfsr,
	input  logic                 start_burst,
	output tes_pkg::chirp_draw_t draw
);

	logic [15:0] l1, l2, l3;
	logic [15:0] freq_src, dur_src, gap_src;

	assign l1 = tes_pkg::lfsr_step(lfsr);
	assign l2 = tes_pkg::lfsr_step(l1);
	assign l3 = tes_pkg::lfsr_step(l2);

	// Burst start draws gap, freq, dur; a tick chirp draws freq, dur, gap
	assign freq_src = start_burst ? l2 : l1;
	assign dur_src  = start_burst ? l3 : l2;
	assign gap_src  = start_burst ? l1 : l3;

	always_comb begin
		draw.freq = 12'(tes_pkg::FREQ_LOW) + 12'(tes_pkg::rem_const(freq_src,
			10'(tes_pkg::FREQ_SPAN), 11'(tes_pkg::FREQ_K)));
		draw.dur  = 10'(tes_pkg::DUR_LOW) + tes_pkg::rem_const(dur_src,
			10'(tes_pkg::DUR_SPAN), 11'(tes_pkg::DUR_K));
		draw.gap  = 9'(tes_pkg::GAP_LOW) + 9'(tes_pkg::rem_const(gap_src,
			10'(tes_pkg::GAP_SPAN), 11'(tes_pkg::GAP_K)));
		draw.lfsr = l3;
	end

endmodule

/* hw/rtl/tone_effect_sequencer_top.sv */
// tone_effect_sequencer_top: buzzer effect sequencer, input register, one-pass step logic,
// result register. An accepted transaction is stepped from the input register into the
// result register and offered at out_valid; one per cycle unless out_stall holds a result.
// Reset: asynchronous, idle mode, LFSR loaded with the reset seed, both stages empty.
// Depends on tes_pkg and tes_draw.
`timescale 1ns / 1ps

module tone_effect_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [3:0]  effect_id,
	input  logic [9:0]  tick_ms,
	input  logic [7:0]  chirp_count,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  action,
	output logic [11:0] frequency_hz,
	output logic [9:0]  duration_ms,
	output logic        active,
	// seed write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] random_seed
);

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'b001,
		MODE_PLAY  = 3'b010,
		MODE_CHIRP = 3'b100
	} mode_t;

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic [3:0] effect_id_s1;
	logic [9:0] tick_ms_s1;
	logic [7:0] chirp_count_s1;

	// Stage 2: result register
	logic        valid_s2;
	logic [1:0]  action_s2;
	logic [11:0] freq_s2;
	logic [9:0]  dur_s2;
	logic        active_s2;

	// Sequencer state
	mode_t       mode_q;
	logic [2:0]  table_q;
	logic [3:0]  note_q;
	logic [7:0]  chirps_q;
	logic [8:0]  countdown_q;   // always 0..300 between transactions
	logic [15:0] lfsr_q;

	logic s2_free, advance, in_accept;

	// The result register frees up when empty or when its transaction leaves this cycle,
	// so a new command moves through while a result is being taken.
	assign s2_free   = !valid_s2 || !out_stall;
	assign advance   = valid_s1 && s2_free;
	assign in_stall  = valid_s1 && !s2_free;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------
	// Step logic on the stage-1 transaction
	// ------------------------------------------------------------------
	tes_pkg::chirp_draw_t draw;
	tes_pkg::note_t       note;
	logic                 start_burst;
	logic [2:0]           rom_table;
	logic [3:0]           note_inc, rom_index;
	logic signed [10:0]   cd_diff;

	mode_t       mode_n;
	logic [2:0]  table_n;
	logic [3:0]  note_n;
	logic [7:0]  chirps_n;
	logic [8:0]  countdown_n;
	logic [15:0] lfsr_n;
	logic [1:0]  act_n;
	logic [11:0] freq_n;
	logic [9:0]  dur_n;

	// Anything other than a tick that reaches the draw unit is a burst start
	assign start_burst = (opcode_s1 != tes_pkg::OP_TICK);

	tes_draw u_draw (
		.lfsr        (lfsr_q),
		.start_burst (start_burst),
		.draw        (draw)
	);

	// One ROM read: first note of a new table, or the next note of the running one
	assign note_inc  = note_q + 4'd1;
	assign rom_table = (opcode_s1 == tes_pkg::OP_PLAY) ? 3'(effect_id_s1 - tes_pkg::FX_FIRST)
	                                                   : table_q;
	assign rom_index = (opcode_s1 == tes_pkg::OP_PLAY) ? 4'd0 : note_inc;
	assign note      = tes_pkg::note_rom(rom_table, rom_index);

	// Countdown minus elapsed time, never below -1023
	assign cd_diff = $signed({2'b00, countdown_q}) - $signed({1'b0, tick_ms_s1});

	always_comb begin
		mode_n      = mode_q;
		table_n     = table_q;
		note_n      = note_q;
		chirps_n    = chirps_q;
		countdown_n = countdown_q;
		lfsr_n      = lfsr_q;
		act_n       = tes_pkg::ACT_NONE;
		freq_n      = '0;
		dur_n       = '0;

		case (opcode_s1)
			tes_pkg::OP_PLAY: begin
				// A new command drops whatever was running
				mode_n      = MODE_IDLE;
				table_n     = '0;
				note_n      = '0;
				chirps_n    = '0;
				countdown_n = '0;
				if (effect_id_s1 >= tes_pkg::FX_FIRST && effect_id_s1 <= tes_pkg::FX_LAST) begin
					mode_n      = MODE_PLAY;
					table_n     = rom_table;
					act_n       = tes_pkg::ACT_TONE;
					freq_n      = note.freq;
					dur_n       = note.dur;
					countdown_n = note.gap;
				end else if (effect_id_s1 == tes_pkg::FX_BURST) begin
					mode_n      = MODE_CHIRP;
					chirps_n    = tes_pkg::BURST_CHIRPS;
					countdown_n = draw.gap;
					lfsr_n      = draw.lfsr;
					act_n       = tes_pkg::ACT_TONE;
					freq_n      = draw.freq;
					dur_n       = draw.dur;
				end else begin
					act_n = tes_pkg::ACT_SILENCE;
				end
			end
			tes_pkg::OP_CHIRP: begin
				mode_n      = MODE_CHIRP;
				table_n     = '0;
				note_n      = '0;
				chirps_n    = chirp_count_s1;
				countdown_n = draw.gap;
				lfsr_n      = draw.lfsr;
				act_n       = tes_pkg::ACT_TONE;
				freq_n      = draw.freq;
				dur_n       = draw.dur;
			end
			tes_pkg::OP_TICK: begin
				case (mode_q)
					MODE_CHIRP: begin
						if (chirps_q != 8'd0) begin
							// chirps fire strictly below zero
							if (cd_diff[10]) begin
								act_n       = tes_pkg::ACT_TONE;
								freq_n      = draw.freq;
								dur_n       = draw.dur;
								countdown_n = draw.gap;
								lfsr_n      = draw.lfsr;
								chirps_n    = chirps_q - 8'd1;
							end else begin
								countdown_n = cd_diff[8:0];
							end
						end else begin
							// burst used up: silence on this tick
							mode_n      = MODE_IDLE;
							table_n     = '0;
							note_n      = '0;
							countdown_n = '0;
							act_n       = tes_pkg::ACT_SILENCE;
						end
					end
					MODE_PLAY: begin
						// table notes advance at zero or below
						if (cd_diff[10] || cd_diff == 11'sd0) begin
							if (7'(note_inc) < tes_pkg::table_len(table_q)) begin
								note_n      = note_inc;
								act_n       = tes_pkg::ACT_TONE;
								freq_n      = note.freq;
								dur_n       = note.dur;
								countdown_n = note.gap;
							end else begin
								mode_n      = MODE_IDLE;
								table_n     = '0;
								note_n      = '0;
								chirps_n    = '0;
								countdown_n = '0;
								act_n       = tes_pkg::ACT_SILENCE;
							end
						end else begin
							countdown_n = cd_diff[8:0];
						end
					end
					default: begin
						// idle tick: nothing to do
					end
				endcase
			end
			default: begin
				// unused opcode: no state change
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			mode_q      <= MODE_IDLE;
			table_q     <= '0;
			note_q      <= '0;
			chirps_q    <= '0;
			countdown_q <= '0;
			lfsr_q      <= tes_pkg::SEED_RESET;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !advance);
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				mode_q      <= mode_n;
				table_q     <= table_n;
				note_q      <= note_n;
				chirps_q    <= chirps_n;
				countdown_q <= countdown_n;
			end
			// Seed write reloads the generator; a zero seed would lock it, so use 1
			if (cfg_valid) begin
				lfsr_q <= (random_seed == 16'd0) ? 16'd1 : random_seed;
			end else if (advance) begin
				lfsr_q <= lfsr_n;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_accept) begin
			opcode_s1      <= opcode;
			effect_id_s1   <= effect_id;
			tick_ms_s1     <= tick_ms;
			chirp_count_s1 <= chirp_count;
		end
		if (advance) begin
			action_s2 <= act_n;
			freq_s2   <= freq_n;
			dur_s2    <= dur_n;
			active_s2 <= (mode_n != MODE_IDLE);
		end
	end

	assign out_valid    = valid_s2;
	assign action       = action_s2;
	assign frequency_hz = freq_s2;
	assign duration_ms  = dur_s2;
	assign active       = active_s2;

`ifndef ASSERT_OFF
	// Idle state carries no leftover timing or burst count
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> (countdown_q == 9'd0 && chirps_q == 8'd0 && note_q == 4'd0))
		else $error("idle with stale sequencer state");

	// A playing table never points past its last note
	a_note_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_PLAY |-> 7'(note_q) < tes_pkg::table_len(table_q))
		else $error("note index beyond table length");

	// Generator must never reach the all-zero lockup state
	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != 16'd0)
		else $error("LFSR locked at zero");

	// A chirp consumes random bits
	a_chirp_draws: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !cfg_valid && act_n == tes_pkg::ACT_TONE && mode_n == MODE_CHIRP
		|=> lfsr_q != $past(lfsr_q))
		else $error("chirp without LFSR advance");

	// Stage 1 only holds back when the result register is full and blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked result");
`endif

endmodule
